### sv/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants
// Field widths, letter bounds and the control bundle handed to each cell.
// ----------------------------------------------------------------------------
package pac_pkg;

   localparam int BYTE_W   = 8;
   localparam int PERIOD_W = 5;
   localparam int MATCH_W  = 24;

   localparam logic [BYTE_W-1:0]   CHAR_LO          = 8'h61;
   localparam logic [BYTE_W-1:0]   CHAR_HI          = 8'h7a;
   localparam logic [PERIOD_W-1:0] MAX_PERIOD_RESET = 5'd16;

   typedef struct packed {
      logic accept;
      logic last_txn;
      logic shift_snap;
   } pac_ctl_type;

   function automatic logic lower_char(input logic [BYTE_W-1:0] b);
      return (b >= CHAR_LO) && (b <= CHAR_HI);
   endfunction

endpackage

### sv/pac_if.sv
// ----------------------------------------------------------------------------
// pac_req_if / pac_rsp_if: valid-ready channels
// Text byte transactions in, per-period count transactions out.
// ----------------------------------------------------------------------------
interface pac_req_if import pac_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface pac_rsp_if import pac_pkg::*;;
   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] period;
   logic [MATCH_W-1:0]  match_count;
   logic                too_long;
   logic                last_result;

   modport source (output valid, output period, output match_count, output too_long,
                   output last_result, input ready);
   modport sink   (input valid, input period, input match_count, input too_long,
                   input last_result, output ready);
endinterface

### sv/periodic_autocorrelation_count.sv
// ----------------------------------------------------------------------------
// periodic_autocorrelation_count: coincidence counts per shift period
// Throughput: one text byte per cycle through a row of MAX_PERIOD cells, save
// that a final byte waits while the previous text's results still drain.
// Results: after each final byte, one per cycle while the result side is ready,
// as many in all as max_period clamped to the range 1..MAX_PERIOD.
// Reset: max_period to 16, history marked invalid and counters cleared, no results pending.
// ----------------------------------------------------------------------------
module periodic_autocorrelation_count import pac_pkg::*; #(
   parameter int MAX_PERIOD = 16,
   parameter int COUNT_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   pac_req_if.sink             req_bus,
   pac_rsp_if.source           rsp_bus,
   input  logic                csr_wr_en,
   input  logic [PERIOD_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_PERIOD + 1);
   localparam int LIM_W = (IDX_W > PERIOD_W) ? IDX_W : PERIOD_W;

   logic [BYTE_W-1:0]     hist_byte [MAX_PERIOD];
   logic                  hist_vld  [MAX_PERIOD];
   logic [COUNT_BITS-1:0] snap_cnt  [MAX_PERIOD];
   logic                  snap_long [MAX_PERIOD];

   logic [PERIOD_W-1:0]   max_period_ff, max_period_in;
   logic                  drain_ff,      drain_in;
   logic [LIM_W-1:0]      period_ff,     period_in;
   logic [LIM_W-1:0]      limit_ff,      limit_in;
   logic                  rsp_vld_ff,    rsp_vld_in;
   logic [LIM_W-1:0]      rsp_period_ff, rsp_period_in;
   logic [COUNT_BITS-1:0] rsp_cnt_ff,    rsp_cnt_in;
   logic                  rsp_long_ff,   rsp_long_in;
   logic                  rsp_last_ff,   rsp_last_in;

   logic                  accept;
   logic                  advance;
   logic [LIM_W-1:0]      max_ext;
   logic [LIM_W-1:0]      limit_clamped;
   logic [COUNT_BITS+MATCH_W-1:0] cnt_ext;
   pac_ctl_type           ctl;

   // hold final bytes back while the snapshot chain is still draining
   assign req_bus.ready = !(drain_ff && req_bus.final_byte);
   assign accept        = req_bus.valid && req_bus.ready;
   assign advance       = drain_ff && (!rsp_vld_ff || rsp_bus.ready);

   assign ctl.accept     = accept;
   assign ctl.last_txn   = req_bus.final_byte;
   assign ctl.shift_snap = advance;

   genvar i;
   generate
      for (i = 0; i < MAX_PERIOD; i++) begin : g_cell
         logic [BYTE_W-1:0]     sh_byte;
         logic                  sh_vld;
         logic [COUNT_BITS-1:0] nx_cnt;
         logic                  nx_long;

         if (i == 0) begin : g_head
            assign sh_byte = req_bus.text_byte;
            assign sh_vld  = 1'b1;
         end else begin : g_body
            assign sh_byte = hist_byte[i-1];
            assign sh_vld  = hist_vld[i-1];
         end

         if (i == MAX_PERIOD - 1) begin : g_tail
            assign nx_cnt  = '0;
            assign nx_long = 1'b0;
         end else begin : g_link
            assign nx_cnt  = snap_cnt[i+1];
            assign nx_long = snap_long[i+1];
         end

         pac_cell #(
            .COUNT_BITS (COUNT_BITS)
         ) u_cell (
            .clock          (clock),
            .reset          (reset),
            .ctl            (ctl),
            .new_byte       (req_bus.text_byte),
            .shift_byte     (sh_byte),
            .shift_vld      (sh_vld),
            .snap_cnt_next  (nx_cnt),
            .snap_long_next (nx_long),
            .hist_byte      (hist_byte[i]),
            .hist_vld       (hist_vld[i]),
            .snap_cnt       (snap_cnt[i]),
            .snap_long      (snap_long[i])
         );
      end
   endgenerate

   assign max_ext = LIM_W'(max_period_ff);

   always_comb begin
      priority if (max_ext == '0) begin
         limit_clamped = LIM_W'(1);
      end else if (max_ext > LIM_W'(MAX_PERIOD)) begin
         limit_clamped = LIM_W'(MAX_PERIOD);
      end else begin
         limit_clamped = max_ext;
      end
   end

   always_comb begin
      max_period_in = max_period_ff;
      drain_in      = drain_ff;
      period_in     = period_ff;
      limit_in      = limit_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_period_in = rsp_period_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_long_in   = rsp_long_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_wr_en) begin
         max_period_in = csr_wr_data;
      end

      if (advance) begin
         rsp_vld_in    = 1'b1;
         rsp_period_in = period_ff;
         rsp_cnt_in    = snap_cnt[0];
         rsp_long_in   = snap_long[0];
         rsp_last_in   = (period_ff == limit_ff);
         if (period_ff == limit_ff) begin
            drain_in = 1'b0;
         end else begin
            period_in = period_ff + 1'b1;
         end
      end else if (rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end

      if (accept && req_bus.final_byte) begin
         drain_in  = 1'b1;
         period_in = LIM_W'(1);
         limit_in  = limit_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_period_ff <= MAX_PERIOD_RESET;
         drain_ff      <= 1'b0;
         period_ff     <= '0;
         limit_ff      <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         max_period_ff <= max_period_in;
         drain_ff      <= drain_in;
         period_ff     <= period_in;
         limit_ff      <= limit_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      rsp_period_ff <= rsp_period_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_long_ff   <= rsp_long_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign cnt_ext = {{MATCH_W{1'b0}}, rsp_cnt_ff};

   assign rsp_bus.valid       = rsp_vld_ff;
   assign rsp_bus.period      = rsp_period_ff[PERIOD_W-1:0];
   assign rsp_bus.match_count = cnt_ext[MATCH_W-1:0];
   assign rsp_bus.too_long    = rsp_long_ff;
   assign rsp_bus.last_result = rsp_last_ff;

   a_long_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_long_ff |-> rsp_cnt_ff == '0)
      else $error("too_long result carries a nonzero count");

   a_drain_start : assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.final_byte |=> drain_ff && (period_ff == LIM_W'(1)))
      else $error("final transaction did not start the drain");

   a_more_follow : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_last_ff |-> drain_ff)
      else $error("non-last result without a pending drain");

   a_period_bound : assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> (period_ff <= limit_ff) && (period_ff != '0))
      else $error("drain period outside 1..limit");

endmodule

### sv/pac_cell.sv
// ----------------------------------------------------------------------------
// pac_cell: one period of the coincidence chain
// Holds one history byte and its counter, and one snapshot slot of the drain.
// ----------------------------------------------------------------------------
module pac_cell import pac_pkg::*; #(
   parameter int COUNT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pac_ctl_type           ctl,
   input  logic [BYTE_W-1:0]     new_byte,
   input  logic [BYTE_W-1:0]     shift_byte,
   input  logic                  shift_vld,
   input  logic [COUNT_BITS-1:0] snap_cnt_next,
   input  logic                  snap_long_next,
   output logic [BYTE_W-1:0]     hist_byte,
   output logic                  hist_vld,
   output logic [COUNT_BITS-1:0] snap_cnt,
   output logic                  snap_long
);

   logic [BYTE_W-1:0]     hist_ff,      hist_in;
   logic                  vld_ff,       vld_in;
   logic [COUNT_BITS-1:0] cnt_ff,       cnt_in;
   logic [COUNT_BITS-1:0] snap_cnt_ff,  snap_cnt_in;
   logic                  snap_long_ff, snap_long_in;
   logic                  hit;
   logic [COUNT_BITS-1:0] cnt_inc;

   assign hit = vld_ff && lower_char(hist_ff) && lower_char(new_byte)
                && (hist_ff == new_byte);
   assign cnt_inc = (hit && !(&cnt_ff)) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      hist_in      = hist_ff;
      vld_in       = vld_ff;
      cnt_in       = cnt_ff;
      snap_cnt_in  = snap_cnt_ff;
      snap_long_in = snap_long_ff;
      if (ctl.accept) begin
         if (ctl.last_txn) begin
            // snapshot the finished text, clear for the next one
            hist_in      = '0;
            vld_in       = 1'b0;
            cnt_in       = '0;
            snap_cnt_in  = cnt_inc;
            snap_long_in = !shift_vld;
         end else begin
            hist_in = shift_byte;
            vld_in  = shift_vld;
            cnt_in  = cnt_inc;
         end
      end
      if (ctl.shift_snap) begin
         snap_cnt_in  = snap_cnt_next;
         snap_long_in = snap_long_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
      hist_ff      <= hist_in;
      snap_cnt_ff  <= snap_cnt_in;
      snap_long_ff <= snap_long_in;
   end

   assign hist_byte = hist_ff;
   assign hist_vld  = vld_ff;
   assign snap_cnt  = snap_cnt_ff;
   assign snap_long = snap_long_ff;

endmodule

### test/tb_periodic_autocorrelation_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_autocorrelation_count: self-checking bench for the coincidence
// counter
// Texts go in one byte transaction at a time. A local model keeps its own byte
// history, per-period counters and text length. On each final byte it queues
// the per-period count transactions that it expects, and the monitor compares
// them in order. A directed script covers the letter bounds, bytes that are
// not letters, short texts and the register extremes, including a write
// between two bytes of one text. Random texts then run under several
// max_period values, with random stalls on both channels, one phase with no
// stalls and one long hold on the result side.
// ----------------------------------------------------------------------------
module tb_periodic_autocorrelation_count;
   import pac_pkg::*;

   localparam int NUM_PERIODS  = 16;
   localparam int RANDOM_BYTES = 480;
   localparam int NUM_PHASES   = 8;
   localparam int RSP_HOLD     = 300;
   localparam int SETTLE       = 20;
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 50;

   typedef enum logic {ROW_TEXT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [BYTE_W-1:0]   data;
      logic                fin;
      logic                typed;
      logic [PERIOD_W-1:0] n_res;
      logic [PERIOD_W-1:0] text_len;
   } stim_row_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [MATCH_W-1:0]  match_count;
      logic                too_long;
      logic                last_result;
   } count_txn_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [PERIOD_W-1:0] csr_wr_data;

   pac_req_if req_bus ();
   pac_rsp_if rsp_bus ();

   periodic_autocorrelation_count DUT (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [BYTE_W-1:0]   seen_bytes [NUM_PERIODS];
   logic [MATCH_W-1:0]  pair_counts [NUM_PERIODS];
   logic [MATCH_W-1:0]  bytes_in_text;
   logic [PERIOD_W-1:0] max_period_reg;
   count_txn_type       counts_due [$];

   int   errors       = 0;
   int   bytes_sent   = 0;
   int   idle_cycles  = 0;
   logic no_idle      = 1'b0;
   logic hold_request = 1'b0;

   // kind, byte, final, typed, results, text length
   stim_row_type script [23] = '{
      '{ROW_TEXT, 8'h61, 1'b1, 1'b1, 5'd16, 5'd1},
      '{ROW_TEXT, 8'h41, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h41, 1'b1, 1'b1, 5'd16, 5'd2},
      '{ROW_TEXT, 8'h00, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'hff, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'he1, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'he1, 1'b1, 1'b1, 5'd16, 5'd4},
      '{ROW_TEXT, 8'h60, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h7b, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h60, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h7b, 1'b1, 1'b1, 5'd16, 5'd4},
      '{ROW_TEXT, 8'h7a, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h7a, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h61, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h7a, 1'b1, 1'b0, 5'd0,  5'd0},
      '{ROW_CSR,  8'd0,  1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h71, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h71, 1'b1, 1'b0, 5'd0,  5'd0},
      '{ROW_CSR,  8'd31, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h6d, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_CSR,  8'd1,  1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h6d, 1'b0, 1'b0, 5'd0,  5'd0},
      '{ROW_TEXT, 8'h6d, 1'b1, 1'b0, 5'd0,  5'd0}
   };

   function automatic void clear_text();
      for (int i = 0; i < NUM_PERIODS; i++) begin
         seen_bytes[i]  = '0;
         pair_counts[i] = '0;
      end
      bytes_in_text = '0;
   endfunction

   task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic fin, input logic typed,
                              input logic [PERIOD_W-1:0] typed_n,
                              input logic [PERIOD_W-1:0] typed_len);
      int            lim;
      logic          b_letter;
      count_txn_type txn;
      b_letter = (b >= CHAR_LO) && (b <= CHAR_HI);
      for (int t = 1; t <= NUM_PERIODS; t++) begin
         if (bytes_in_text >= t && b_letter && seen_bytes[t-1] == b && pair_counts[t-1] != '1)
            pair_counts[t-1] = pair_counts[t-1] + 1'b1;
      end
      for (int i = NUM_PERIODS - 1; i > 0; i--)
         seen_bytes[i] = seen_bytes[i-1];
      seen_bytes[0] = b;
      if (bytes_in_text != '1)
         bytes_in_text = bytes_in_text + 1'b1;
      if (fin) begin
         if (max_period_reg == 0)
            lim = 1;
         else if (max_period_reg > NUM_PERIODS)
            lim = NUM_PERIODS;
         else
            lim = int'(max_period_reg);
         if (typed)
            lim = int'(typed_n);
         for (int t = 1; t <= lim; t++) begin
            txn.period = PERIOD_W'(t);
            if (typed) begin
               txn.too_long    = (t > typed_len);
               txn.match_count = '0;
            end else begin
               txn.too_long    = (t > bytes_in_text);
               txn.match_count = txn.too_long ? '0 : pair_counts[t-1];
            end
            txn.last_result = (t == lim);
            counts_due.push_back(txn);
         end
         clear_text();
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin,
                            input logic typed = 1'b0,
                            input logic [PERIOD_W-1:0] typed_n = '0,
                            input logic [PERIOD_W-1:0] typed_len = '0);
      while (!no_idle && $urandom_range(0, 99) < 36) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.text_byte  <= b;
      req_bus.final_byte <= fin;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      absorb_byte(b, fin, typed, typed_n, typed_len);
   endtask

   // hold the input until every queued count transaction has come out
   task automatic drain_counts();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (counts_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_max_period(input logic [PERIOD_W-1:0] value);
      drain_counts();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      max_period_reg = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_text();
      int                len;
      int                alpha;
      int                pick;
      logic [BYTE_W-1:0] b;
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 18);
      alpha = $urandom_range(1, 26);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 75)
            b = CHAR_LO + BYTE_W'($urandom_range(0, alpha - 1));
         else if (pick < 85)
            b = CHAR_LO + BYTE_W'($urandom_range(0, 25));
         else if (pick < 92)
            b = $urandom_range(0, 1) ? CHAR_LO - 8'd1 : CHAR_HI + 8'd1;
         else
            b = BYTE_W'($urandom_range(0, 255));
         send_byte(b, i == len - 1);
         bytes_sent++;
      end
   endtask

   initial begin : stimulus
      int                  phase_end;
      logic [PERIOD_W-1:0] setting;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.text_byte  = '0;
      req_bus.final_byte = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      clear_text();
      max_period_reg = MAX_PERIOD_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR)
            write_max_period(script[i].data[PERIOD_W-1:0]);
         else
            send_byte(script[i].data, script[i].fin, script[i].typed, script[i].n_res,
                      script[i].text_len);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin
               setting = 5'd16;
            end
            1: begin
               setting = 5'd1;
            end
            2: begin
               setting = 5'd0;
            end
            3: begin
               setting = 5'd31;
            end
            default: begin
               setting = PERIOD_W'($urandom_range(0, 31));
            end
         endcase
         write_max_period(setting);
         no_idle = (ph == 5);
         if (ph == 3)
            hold_request = 1'b1;
         phase_end = bytes_sent + RANDOM_BYTES / NUM_PHASES;
         while (bytes_sent < phase_end) begin
            send_random_text();
            if ($urandom_range(0, 19) == 0)
               drain_counts();
         end
      end
      no_idle = 1'b0;

      drain_counts();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : rsp_side
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
         end
         rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= 36);
      end
   end

   always @(posedge clock) begin : check_counts
      count_txn_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (counts_due.size() == 0) begin
            report_mismatch("unexpected count transaction, period", rsp_bus.period, 0);
         end else begin
            want = counts_due.pop_front();
            if (rsp_bus.period !== want.period)
               report_mismatch("period", rsp_bus.period, want.period);
            if (rsp_bus.match_count !== want.match_count)
               report_mismatch("match_count", rsp_bus.match_count, want.match_count);
            if (rsp_bus.too_long !== want.too_long)
               report_mismatch("too_long", rsp_bus.too_long, want.too_long);
            if (rsp_bus.last_result !== want.last_result)
               report_mismatch("last_result", rsp_bus.last_result, want.last_result);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

endmodule

### files.f
sv/pac_pkg.sv
sv/pac_if.sv
sv/pac_cell.sv
sv/periodic_autocorrelation_count.sv
test/tb_periodic_autocorrelation_count.sv
